// ===== sv/atcb_pkg.sv =====
// ----------------------------------------------------------------------------
// atcb_pkg
// Shared constants and types of the binned AT content block.
// ----------------------------------------------------------------------------
package atcb_pkg;

   // byte codes
   localparam logic [7:0] ASCII_NL    = 8'h0A;
   localparam logic [7:0] ASCII_GT    = 8'h3E;
   localparam logic [7:0] ASCII_A     = 8'h41;
   localparam logic [7:0] ASCII_T     = 8'h54;
   localparam logic [7:0] ASCII_U     = 8'h55;
   localparam logic [7:0] LOWER_A     = 8'h61;
   localparam logic [7:0] LOWER_Z     = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   // bin size after reset
   localparam logic [15:0] BIN_SIZE_RESET = 16'd100;

   // percent in 1/256 units: at * 100 * 256 / bases
   localparam logic [6:0]  PCT_SCALE = 7'd100;
   localparam int          SCALE_W   = 7;
   localparam int          FRAC_BITS = 8;
   localparam int          PCT_BITS  = 15;
   localparam logic [14:0] PCT_FULL  = 15'd25600;

   // depth of the bin queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic is_final;
      logic last;
   } atcb_flags_type;

endpackage

// ===== sv/atcb_front.sv =====
// ----------------------------------------------------------------------------
// atcb_front
// Parses the byte stream, counts bases and AT per bin, queues closed bins.
// ----------------------------------------------------------------------------
module atcb_front #(
   parameter int COUNT_WIDTH = 16,
   parameter int JOB_W       = 32 + 2 * COUNT_WIDTH + 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_byte_in,
   input  logic             req_end_of_input,
   input  logic             csr_write_enable,
   input  logic [15:0]      csr_bin_size,
   input  logic             queue_full,
   output logic             push_valid,
   output logic [JOB_W-1:0] push_data
);

   localparam int EW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   function automatic logic [COUNT_WIDTH-1:0] clamp_size(input logic [15:0] s);
      logic [EW-1:0] se;
      logic [EW-1:0] me;
      logic [EW-1:0] r;
      se = EW'(s);
      me = EW'(CNT_MAX);
      r  = (se > me) ? me : se;
      if (r == '0) begin
         r = EW'(1);
      end
      return COUNT_WIDTH'(r);
   endfunction

   localparam logic [COUNT_WIDTH-1:0] EFF_RESET = clamp_size(atcb_pkg::BIN_SIZE_RESET);

   logic [15:0]            bin_size_ff;
   logic [COUNT_WIDTH-1:0] bases_ff;
   logic [COUNT_WIDTH-1:0] at_ff;
   logic [31:0]            pos_ff;
   logic                   line_start_ff;
   logic                   header_ff;
   logic                   pend_valid_ff;
   logic [JOB_W-1:0]       pend_data_ff;

   logic [COUNT_WIDTH-1:0] eff_size;
   logic [COUNT_WIDTH-1:0] csr_eff;
   logic                   accept;
   logic                   is_nl;
   logic                   header_in;
   logic                   is_base;
   logic [7:0]             ucase;
   logic                   is_at;
   logic [COUNT_WIDTH-1:0] bases_inc;
   logic [COUNT_WIDTH-1:0] at_inc;
   logic                   bin_full;
   logic [31:0]            pos_full;
   logic [COUNT_WIDTH-1:0] bases_rem;
   logic [COUNT_WIDTH-1:0] at_rem;
   logic [31:0]            pos_rem;
   logic [JOB_W-1:0]       full_job;
   logic [JOB_W-1:0]       final_job;
   atcb_pkg::atcb_flags_type full_flags;
   atcb_pkg::atcb_flags_type final_flags;

   assign eff_size  = clamp_size(bin_size_ff);
   assign csr_eff   = clamp_size(csr_bin_size);
   assign req_ready = !pend_valid_ff && !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      is_nl     = (req_byte_in == atcb_pkg::ASCII_NL);
      header_in = is_nl ? 1'b0
                        : (header_ff || (line_start_ff && req_byte_in == atcb_pkg::ASCII_GT));
      is_base   = !is_nl && !header_in;
      ucase     = (req_byte_in >= atcb_pkg::LOWER_A && req_byte_in <= atcb_pkg::LOWER_Z)
                  ? (req_byte_in - atcb_pkg::CASE_OFFSET) : req_byte_in;
      is_at     = (ucase == atcb_pkg::ASCII_A) || (ucase == atcb_pkg::ASCII_T)
                  || (ucase == atcb_pkg::ASCII_U);
      bases_inc = bases_ff + COUNT_WIDTH'(is_base);
      at_inc    = at_ff + COUNT_WIDTH'(is_base && is_at);
      bin_full  = is_base && (bases_inc >= eff_size);
      pos_full  = pos_ff + 32'(eff_size);
      bases_rem = bin_full ? '0 : bases_inc;
      at_rem    = bin_full ? '0 : at_inc;
      pos_rem   = bin_full ? pos_full : pos_ff;

      full_flags.is_final  = 1'b0;
      full_flags.last      = !req_end_of_input;
      final_flags.is_final = 1'b1;
      final_flags.last     = 1'b1;
      full_job  = {pos_full, at_inc, bases_inc, full_flags};
      final_job = {pos_rem + 32'(bases_rem), at_rem, bases_rem, final_flags};

      if (pend_valid_ff) begin
         push_valid = !queue_full;
         push_data  = pend_data_ff;
      end else begin
         push_valid = accept && (bin_full || req_end_of_input);
         push_data  = bin_full ? full_job : final_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_size_ff   <= atcb_pkg::BIN_SIZE_RESET;
         bases_ff      <= '0;
         at_ff         <= '0;
         pos_ff        <= 32'd0 - 32'(EFF_RESET >> 1);
         line_start_ff <= 1'b1;
         header_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else if (csr_write_enable) begin
         // new bin size restarts the stream
         bin_size_ff   <= csr_bin_size;
         bases_ff      <= '0;
         at_ff         <= '0;
         pos_ff        <= 32'd0 - 32'(csr_eff >> 1);
         line_start_ff <= 1'b1;
         header_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (pend_valid_ff && !queue_full) begin
            pend_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (bin_full && req_end_of_input) begin
               pend_valid_ff <= 1'b1;
               pend_data_ff  <= final_job;
            end
            if (req_end_of_input) begin
               bases_ff      <= '0;
               at_ff         <= '0;
               pos_ff        <= 32'd0 - 32'(eff_size >> 1);
               line_start_ff <= 1'b1;
               header_ff     <= 1'b0;
            end else begin
               bases_ff      <= bases_rem;
               at_ff         <= at_rem;
               pos_ff        <= pos_rem;
               line_start_ff <= is_nl;
               header_ff     <= header_in;
            end
         end
      end
   end

   a_pend_blocks_input: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> !req_ready)
      else $error("front accepts a byte while a final bin is pending");

   a_double_bin_pends: assert property (@(posedge clock) disable iff (reset)
      (accept && bin_full && req_end_of_input && !csr_write_enable) |=> pend_valid_ff)
      else $error("final bin after a full bin was not held");

endmodule

// ===== sv/atcb_fifo.sv =====
// ----------------------------------------------------------------------------
// atcb_fifo
// Short queue of closed bins between the front and the back.
// ----------------------------------------------------------------------------
module atcb_fifo #(
   parameter int WIDTH = 66,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            entry_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("bin pushed into a full queue");

endmodule

// ===== sv/atcb_back.sv =====
// ----------------------------------------------------------------------------
// atcb_back
// Turns a closed bin into a result: scale, divide bit by bit, register out.
// ----------------------------------------------------------------------------
module atcb_back #(
   parameter int COUNT_WIDTH = 16,
   parameter int JOB_W       = 32 + 2 * COUNT_WIDTH + 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  logic [JOB_W-1:0]  job_data,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [31:0] rsp_bin_position,
   output logic [14:0]       rsp_percent_q8,
   output logic [15:0]       rsp_bin_bases,
   output logic              rsp_is_final_bin,
   output logic              rsp_last
);

   localparam int MW = COUNT_WIDTH + atcb_pkg::SCALE_W;
   localparam int LO = atcb_pkg::PCT_BITS - atcb_pkg::FRAC_BITS;
   localparam int SW = $clog2(atcb_pkg::PCT_BITS);
   localparam logic [SW-1:0] STEP_LAST = SW'(atcb_pkg::PCT_BITS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_DONE
   } state_type;

   state_type                   state_ff;
   logic [31:0]                 pos_ff;
   logic [COUNT_WIDTH-1:0]      at_ff;
   logic [COUNT_WIDTH-1:0]      bases_ff;
   atcb_pkg::atcb_flags_type    flags_ff;
   logic [COUNT_WIDTH-1:0]      rem_ff;
   logic [atcb_pkg::PCT_BITS-1:0] num_ff;
   logic [atcb_pkg::PCT_BITS-1:0] quo_ff;
   logic [SW-1:0]               step_ff;
   logic                        out_valid_ff;

   logic [31:0]                 job_pos;
   logic [COUNT_WIDTH-1:0]      job_at;
   logic [COUNT_WIDTH-1:0]      job_bases;
   atcb_pkg::atcb_flags_type    job_flags;
   logic [MW-1:0]               prod;
   logic [COUNT_WIDTH:0]        trial;
   logic [COUNT_WIDTH:0]        diff;
   logic                        qbit;

   assign {job_pos, job_at, job_bases, job_flags} = job_data;
   assign job_pop   = (state_ff == S_IDLE) && job_valid;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      prod  = MW'(at_ff) * MW'(atcb_pkg::PCT_SCALE);
      trial = {rem_ff, num_ff[atcb_pkg::PCT_BITS-1]};
      diff  = trial - {1'b0, bases_ff};
      qbit  = !diff[COUNT_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_ready && state_ff != S_DONE) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  pos_ff   <= job_pos;
                  at_ff    <= job_at;
                  bases_ff <= job_bases;
                  flags_ff <= job_flags;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               // at <= bases, so the top part of the numerator is below the divisor
               rem_ff   <= prod[MW-1:LO];
               num_ff   <= {prod[LO-1:0], atcb_pkg::FRAC_BITS'(0)};
               quo_ff   <= '0;
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff  <= qbit ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
               num_ff  <= num_ff << 1;
               quo_ff  <= {quo_ff[atcb_pkg::PCT_BITS-2:0], qbit};
               step_ff <= step_ff + SW'(1);
               if (step_ff == STEP_LAST) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!out_valid_ff || rsp_ready) begin
                  out_valid_ff     <= 1'b1;
                  rsp_bin_position <= pos_ff;
                  rsp_percent_q8   <= (bases_ff == '0) ? '0 : quo_ff;
                  rsp_bin_bases    <= 16'(bases_ff);
                  rsp_is_final_bin <= flags_ff.is_final;
                  rsp_last         <= flags_ff.last;
                  state_ff         <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (step_ff <= STEP_LAST))
      else $error("divider ran past its last quotient bit");

   a_percent_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_percent_q8 <= atcb_pkg::PCT_FULL))
      else $error("percent above one hundred");

endmodule

// ===== sv/at_content_binner.sv =====
// ----------------------------------------------------------------------------
// at_content_binner
// Binned AT content of a FASTA byte stream, one byte per request.
// ----------------------------------------------------------------------------
// The front takes one byte per cycle unless the queue is full or a final bin
// is held: header lines starting with '>' are skipped to the newline,
// newlines are not bases, and a, t, u, A, T, U count as AT. Every closed bin
// (bin_size bases, or the partial bin flushed after a byte marked
// end_of_input) goes into a four-entry queue. The back works one bin at a
// time and in order: it takes the bin from the queue, multiplies by 100,
// runs the bit-per-cycle division that gives the percent in 1/256 units, and
// loads the output register, where it waits while the receiver stalls. When
// bins close faster than the back finishes them, the queue fills and the
// stream is held back. A byte that both completes a full bin and ends the
// input yields two results and blocks the input until the second one has
// entered the queue.
// Writing csr_bin_size restarts the stream (counts cleared, position back to
// minus half the bin size); do so only while no request is in flight.
// ----------------------------------------------------------------------------
module at_content_binner #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   // byte requests
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_byte_in,
   input  logic               req_end_of_input,
   // bin results
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_bin_position,
   output logic [14:0]        rsp_percent_q8,
   output logic [15:0]        rsp_bin_bases,
   output logic               rsp_is_final_bin,
   output logic               rsp_last,
   // bin size register
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_bin_size
);

   // queued bin: position, AT count, base count, flags
   localparam int JOB_W = 32 + 2 * COUNT_WIDTH + 2;

   logic             push_valid;
   logic [JOB_W-1:0] push_data;
   logic             queue_full;
   logic             queue_not_empty;
   logic [JOB_W-1:0] queue_data;
   logic             queue_pop;

   // parser and bin counters
   atcb_front #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .JOB_W       (JOB_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .req_end_of_input (req_end_of_input),
      .csr_write_enable (csr_write_enable),
      .csr_bin_size     (csr_bin_size),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_data        (push_data)
   );

   // decouples the byte rate from the per-bin division
   atcb_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (atcb_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (queue_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop_data  (queue_data)
   );

   // percent computation and result register
   atcb_back #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .JOB_W       (JOB_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (queue_not_empty),
      .job_data         (queue_data),
      .job_pop          (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bin_position (rsp_bin_position),
      .rsp_percent_q8   (rsp_percent_q8),
      .rsp_bin_bases    (rsp_bin_bases),
      .rsp_is_final_bin (rsp_is_final_bin),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for at_content_binner. A queue-fed driver offers bytes
// with random gaps, a monitor takes bins with random stalls and compares them
// field by field with the bins that a local tracker of the byte stream works
// out. Directed bytes cover headers, the empty final bin and the double
// result. Random FASTA-like streams and noise then run over several bin sizes.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int         COUNT_W       = 16;
   localparam int         QUIET_LIMIT   = 4000;  // cycles without any handshake
   localparam int         LONG_HOLD     = 300;   // one long receiver stall
   localparam int         SETTLE_CYCLES = 40;    // idle time after every bin is back
   localparam logic [7:0] ASCII_CR      = 8'h0D;

   // one byte request as queued for the driver
   typedef struct {
      logic [7:0] data;
      logic       eoi;
      logic       drain;  // hold this byte until every bin has come back
   } byte_request_type;

   // one bin result
   typedef struct {
      logic signed [31:0] position;
      logic [14:0]        percent;
      logic [15:0]        bases;
      logic               final_bin;
      logic               last;
   } bin_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic [7:0]         req_byte_in      = 8'h00;
   logic               req_end_of_input = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b0;
   logic signed [31:0] rsp_bin_position;
   logic [14:0]        rsp_percent_q8;
   logic [15:0]        rsp_bin_bases;
   logic               rsp_is_final_bin;
   logic               rsp_last;
   logic               csr_write_enable = 1'b0;
   logic [15:0]        csr_bin_size     = atcb_pkg::BIN_SIZE_RESET;

   // pending bytes and the bins they are expected to close
   byte_request_type byte_queue [$];
   bin_result_type   bin_expect [$];

   // local copy of the bin tracking state
   logic [15:0] size_reg;
   logic [15:0] base_count;
   logic [15:0] at_count;
   logic [31:0] run_pos;
   logic        line_start;
   logic        in_header;

   // idle behavior: 0 none, 1 rare gaps, 2 gaps on every item
   int send_mode = 1;
   int recv_mode = 1;
   bit long_hold_arm = 1'b0;

   int mismatches = 0;
   int bytes_sent = 0;
   int bins_seen  = 0;
   int sizes_used = 0;

   string base_alphabet = "ACGTUNacgtunRYswkmBDHV>*-";

   always #6 clock = ~clock;

   at_content_binner #(
      .COUNT_WIDTH(COUNT_W)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_in     (req_byte_in),
      .req_end_of_input(req_end_of_input),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bin_position(rsp_bin_position),
      .rsp_percent_q8  (rsp_percent_q8),
      .rsp_bin_bases   (rsp_bin_bases),
      .rsp_is_final_bin(rsp_is_final_bin),
      .rsp_last        (rsp_last),
      .csr_write_enable(csr_write_enable),
      .csr_bin_size    (csr_bin_size)
   );

   // ---------------------------------------------------------------------
   // bin tracking
   // ---------------------------------------------------------------------

   // a bin size of zero behaves as one
   function automatic logic [15:0] active_size();
      return (size_reg == 16'd0) ? 16'd1 : size_reg;
   endfunction

   // counts cleared, position back to minus half the bin size
   function automatic void restart_bins();
      logic [15:0] half;
      half       = active_size() >> 1;
      base_count = '0;
      at_count   = '0;
      run_pos    = 32'd0 - 32'(half);
      line_start = 1'b1;
      in_header  = 1'b0;
   endfunction

   // snapshot of the open bin, percent truncated in 1/256 units
   function automatic bin_result_type close_bin(input logic final_bin);
      bin_result_type r;
      logic [31:0] scaled;
      scaled      = 32'(at_count) * 32'd25600;
      r.position  = run_pos;
      r.percent   = (base_count == 16'd0) ? 15'd0 : 15'(scaled / 32'(base_count));
      r.bases     = base_count;
      r.final_bin = final_bin;
      r.last      = 1'b0;
      return r;
   endfunction

   // one accepted byte: update the stream state and queue the bins it closes
   task automatic track_byte(input logic [7:0] data, input logic eoi);
      bin_result_type found [2];
      int          n;
      logic [7:0]  upper;
      n = 0;
      if (data == atcb_pkg::ASCII_NL) begin
         line_start = 1'b1;
         in_header  = 1'b0;
      end else begin
         // '>' only opens a header as the first byte of a line
         if (line_start && data == atcb_pkg::ASCII_GT) in_header = 1'b1;
         line_start = 1'b0;
         if (!in_header) begin
            upper = (data >= atcb_pkg::LOWER_A && data <= atcb_pkg::LOWER_Z)
                    ? data - atcb_pkg::CASE_OFFSET : data;
            base_count = base_count + 16'd1;
            if (upper == atcb_pkg::ASCII_A || upper == atcb_pkg::ASCII_T
                || upper == atcb_pkg::ASCII_U)
               at_count = at_count + 16'd1;
            if (base_count >= active_size()) begin
               run_pos  = run_pos + 32'(active_size());
               found[n] = close_bin(1'b0);
               n++;
               base_count = '0;
               at_count   = '0;
            end
         end
      end
      // flush: the partial bin, possibly empty, then a fresh stream
      if (eoi) begin
         run_pos  = run_pos + 32'(base_count);
         found[n] = close_bin(1'b1);
         n++;
         restart_bins();
      end
      for (int i = 0; i < n; i++) begin
         found[i].last = (i == n - 1);
         bin_expect.insert(bin_expect.size(), found[i]);
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   function automatic int draw_gap(input int mode);
      case (mode)
         0: return 0;
         1: return ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 16)) : 0;
         default: return $urandom_range(0, 16);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // driver: one request in flight, payload held until accepted
   // ---------------------------------------------------------------------
   int               send_wait = 0;
   byte_request_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && req_ready) begin
            track_byte(req_byte_in, req_end_of_input);
            bytes_sent++;
         end
         // slot is free when nothing is offered or the offer was just taken
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait <= send_wait - 1;
               req_valid <= 1'b0;
            end else if (byte_queue.size() != 0 &&
                         (!byte_queue[0].drain || bin_expect.size() == 0)) begin
               next_req          = byte_queue.pop_front();
               req_byte_in      <= next_req.data;
               req_end_of_input <= next_req.eoi;
               req_valid        <= 1'b1;
               send_wait        <= draw_gap(send_mode);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: random stalls, one long hold, field by field compare
   // ---------------------------------------------------------------------
   int             recv_wait = 0;
   int             recv_draw;
   int             hold_left = 0;
   bit             long_hold_taken = 1'b0;
   bin_result_type want_bin;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            bins_seen++;
            if (bin_expect.size() == 0) begin
               report_mismatch("bin with nothing expected", rsp_bin_position, 0);
            end else begin
               want_bin = bin_expect.pop_front();
               if (rsp_bin_position !== want_bin.position)
                  report_mismatch("bin_position", rsp_bin_position, want_bin.position);
               if (rsp_percent_q8 !== want_bin.percent)
                  report_mismatch("percent_q8", rsp_percent_q8, want_bin.percent);
               if (rsp_bin_bases !== want_bin.bases)
                  report_mismatch("bin_bases", rsp_bin_bases, want_bin.bases);
               if (rsp_is_final_bin !== want_bin.final_bin)
                  report_mismatch("is_final_bin", rsp_is_final_bin, want_bin.final_bin);
               if (rsp_last !== want_bin.last)
                  report_mismatch("last", rsp_last, want_bin.last);
            end
         end
         // ready low for the drawn number of cycles after each taken bin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= (hold_left == 1);
         end else if (long_hold_arm && !long_hold_taken) begin
            // long stall so the bin queue fills and the input backs up
            long_hold_taken <= 1'b1;
            hold_left       <= LONG_HOLD;
            rsp_ready       <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            rsp_ready <= (recv_wait == 1);
         end else if (rsp_valid && rsp_ready) begin
            recv_draw = draw_gap(recv_mode);
            recv_wait <= recv_draw;
            rsp_ready <= (recv_draw == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: any long stretch with no handshake at all ends the run
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $realtime, QUIET_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] data, input logic eoi);
      byte_request_type item;
      item.data  = data;
      item.eoi   = eoi;
      item.drain = 1'b0;
      byte_queue.insert(byte_queue.size(), item);
   endtask

   function automatic logic [7:0] pick_base();
      if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
      return base_alphabet[$urandom_range(0, base_alphabet.len() - 1)];
   endfunction

   // FASTA-like records: optional header line, sequence lines, mostly flushed
   function automatic int add_stream(input int length, input bit drain);
      byte_request_type chunk [$];
      byte_request_type item;
      int               line_len;
      item.eoi   = 1'b0;
      item.drain = 1'b0;
      while (chunk.size() < length) begin
         if ($urandom_range(0, 2) == 0) begin
            item.data = atcb_pkg::ASCII_GT;
            chunk.insert(chunk.size(), item);
            line_len = $urandom_range(0, 10);
            repeat (line_len) begin
               item.data = 8'($urandom_range(1, 255));
               chunk.insert(chunk.size(), item);
            end
            item.data = atcb_pkg::ASCII_NL;
            chunk.insert(chunk.size(), item);
         end
         line_len = $urandom_range(0, 40);
         repeat (line_len) begin
            item.data = pick_base();
            chunk.insert(chunk.size(), item);
         end
         if ($urandom_range(0, 5) == 0) begin
            item.data = ASCII_CR;
            chunk.insert(chunk.size(), item);
         end
         item.data = atcb_pkg::ASCII_NL;
         chunk.insert(chunk.size(), item);
      end
      // end of input lands on a base, a CR or a newline, or is left out
      if ($urandom_range(0, 1) == 0 && chunk.size() > 1) void'(chunk.pop_back());
      if ($urandom_range(0, 5) != 0) begin
         chunk[chunk.size() - 1].eoi = 1'b1;
      end
      chunk[0].drain = drain;
      foreach (chunk[i]) byte_queue.insert(byte_queue.size(), chunk[i]);
      return chunk.size();
   endfunction

   // raw bytes, any value, with a rare end of input
   function automatic int add_noise(input int count);
      byte_request_type item;
      item.drain = 1'b0;
      repeat (count) begin
         item.data = 8'($urandom_range(0, 255));
         item.eoi  = ($urandom_range(0, 15) == 0);
         byte_queue.insert(byte_queue.size(), item);
      end
      return count;
   endfunction

   // all bytes taken, every bin back, then time for the front to settle
   task automatic wait_idle();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_valid || bin_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // a bin size write also restarts the stream
   task automatic write_bin_size(input logic [15:0] value);
      @(posedge clock);
      csr_bin_size     <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      size_reg = value;
      restart_bins();
      sizes_used++;
      @(negedge clock);
   endtask

   initial begin
      logic [15:0] plan [10];
      int          budget;
      int          made;
      int          streams;
      size_reg = atcb_pkg::BIN_SIZE_RESET;
      restart_bins();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset bin size: header skipped, '>' inside a line counts, CR and
      // lower case; the final partial bin, then a final bin of a single base
      queue_byte(atcb_pkg::ASCII_GT, 1'b0);
      queue_byte("x", 1'b0);
      queue_byte(atcb_pkg::ASCII_NL, 1'b0);
      queue_byte("a", 1'b0);
      queue_byte("T", 1'b0);
      queue_byte(ASCII_CR, 1'b0);
      queue_byte(atcb_pkg::ASCII_GT, 1'b0);
      queue_byte("u", 1'b0);
      queue_byte(atcb_pkg::ASCII_NL, 1'b1);
      queue_byte("u", 1'b1);
      wait_idle();

      // bin size zero acts as one: every base closes a bin, the last
      // byte gives a full bin and an empty final bin
      write_bin_size(16'd0);
      queue_byte("A", 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte("g", 1'b1);
      wait_idle();

      // double result on a real bin, then a stream ending inside a header
      write_bin_size(16'd3);
      queue_byte("t", 1'b0);
      queue_byte("U", 1'b0);
      queue_byte("c", 1'b1);
      queue_byte(atcb_pkg::ASCII_GT, 1'b0);
      queue_byte("a", 1'b0);
      queue_byte("b", 1'b1);

      // random phases over several bin sizes, extremes included
      plan = '{16'd1, 16'd2, 16'd65535, 16'd18, 16'd0, 16'd5, 16'd100, 16'd7, 16'd33,
               16'd1};
      plan[7] = 16'($urandom_range(3, 40));
      plan[8] = 16'($urandom_range(41, 300));
      streams = 0;
      foreach (plan[p]) begin
         wait_idle();
         write_bin_size(plan[p]);
         // first phase: sender never idles while the receiver holds off
         send_mode     = (p == 0) ? 0 : $urandom_range(0, 2);
         recv_mode     = $urandom_range(0, 2);
         long_hold_arm = (p == 0);
         budget        = (plan[p] == 16'd65535) ? 60 : 120;
         made          = 0;
         while (made < budget) begin
            if ($urandom_range(0, 4) == 0) begin
               made += add_noise($urandom_range(1, 12));
            end else begin
               // every fourth stream waits for all bins before it starts
               made += add_stream($urandom_range(10, 80), (streams % 4 == 3));
               streams++;
            end
         end
      end
      wait_idle();

      if (bin_expect.size() != 0)
         report_mismatch("bins never returned", 0, bin_expect.size());
      $display("run covered %0d byte requests and %0d bins over %0d bin size writes",
               bytes_sent, bins_seen, sizes_used);
      $display("headers, empty and double final bins, random stalls, one long hold");
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
